### rtl/core/lsfm_pkg.sv
// lsfm_pkg: shared types and constants for the looped sample fetch and mix block
// used by lsfm_rem_unit and looped_sample_fetch_mix; no dependencies
package lsfm_pkg;

  localparam int POS_W = 32;
  localparam int CFG_W = 16;
  localparam int CIDX_W = 3;
  localparam int LEN_W = 15;   // doubled ping-pong loop length and loop end fit here

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_FWD  = 2'd1;
  localparam logic [1:0] MODE_PING = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_MIX   = 1'b1;

  localparam logic [CIDX_W-1:0] CFG_LOOP_MODE     = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_LOOP_START    = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_LOOP_END      = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_SAMPLE_LENGTH = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_GAIN_LEFT     = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_GAIN_RIGHT    = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_GAIN_SHIFT    = 3'd6;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_WRAP  = 9'b000000010,
    ST_DIV   = 9'b000000100,
    ST_INDEX = 9'b000001000,
    ST_READ  = 9'b000010000,
    ST_MUL_L = 9'b000100000,
    ST_MUL_R = 9'b001000000,
    ST_ADD_R = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_status_t;

endpackage

### rtl/core/looped_sample_fetch_mix.sv
// Wavetable sample playback: write items load a stereo sample store, mix items wrap a
// playback position by the loop mode, fetch the sample and add the scaled channels to the
// accumulators. A mix item steps through the wrap, index, read, multiply and add states
// to the done state, held there while the output register is full. A position at or past
// the loop end (the doubled loop in ping-pong mode) also waits in the divide state for
// the remainder unit: direct for an offset below the loop length, else one bit a cycle.
// Invalid items skip the read and the multiplies and finish sooner. One multiplier serves
// both channels in turn and the store is read through one registered port. The next item
// is accepted while a result waits in the output register. The store holds no reset
// value: the user must write every entry before it is read; the block does not check it.
module looped_sample_fetch_mix #(
  parameter int STORE_DEPTH = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [lsfm_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [lsfm_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         opcode,
  input  logic [11:0]                  write_index,
  input  logic signed [15:0]           write_left,
  input  logic signed [15:0]           write_right,
  input  logic [31:0]                  play_position,
  input  logic signed [31:0]           accum_left,
  input  logic signed [31:0]           accum_right,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [31:0]           mixed_left,
  output logic signed [31:0]           mixed_right,
  output logic [31:0]                  wrapped_position,
  output logic                         position_valid
);
  import lsfm_pkg::*;

  localparam int WB = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PW = WB + 17;
  localparam logic [POS_W-1:0] DEPTH32 = POS_W'(STORE_DEPTH);

  // configuration
  logic [1:0]  loop_mode;
  logic [12:0] loop_start;
  logic [12:0] loop_end;
  logic [12:0] sample_length;
  logic [15:0] gain_left;
  logic [15:0] gain_right;
  logic [4:0]  gain_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_mode     <= '0;
      loop_start    <= '0;
      loop_end      <= '0;
      sample_length <= '0;
      gain_left     <= '0;
      gain_right    <= '0;
      gain_shift    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LOOP_MODE:     loop_mode     <= cfg_data[1:0];
        CFG_LOOP_START:    loop_start    <= cfg_data[12:0];
        CFG_LOOP_END:      loop_end      <= cfg_data[12:0];
        CFG_SAMPLE_LENGTH: sample_length <= cfg_data[12:0];
        CFG_GAIN_LEFT:     gain_left     <= cfg_data;
        CFG_GAIN_RIGHT:    gain_right    <= cfg_data;
        CFG_GAIN_SHIFT:    gain_shift    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // sample store, left in the upper half
  logic [2*WB-1:0] mem [STORE_DEPTH];
  logic [AW-1:0]   rd_addr;
  logic [2*WB-1:0] rd_data;

  state_t state;
  state_t state_next;

  logic              accept;
  logic              store_write;
  logic [POS_W-1:0]  pos;
  logic signed [31:0] acc_l;
  logic signed [31:0] acc_r;
  logic signed [31:0] mix_l;
  logic signed [31:0] mix_r;
  logic              valid;

  assign in_ready    = (state == ST_IDLE);
  assign accept      = in_valid && in_ready;
  assign store_write = accept && (opcode == OP_WRITE)
                       && ({20'd0, write_index} < DEPTH32);

  always_ff @(posedge clk) begin
    if (store_write) begin
      mem[AW'(write_index)] <= {write_left[WB-1:0], write_right[WB-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  // loop geometry
  logic              looped;
  logic              ping;
  logic              loop_bad;
  logic [12:0]       len13;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  vend;
  logic [POS_W-1:0]  vend32;
  logic [POS_W-1:0]  end32;
  logic [POS_W-1:0]  mirror;
  logic [POS_W-1:0]  idx;
  logic [POS_W-1:0]  limit;
  logic              pos_reserved;
  logic              need_rem;
  logic              idx_bad;

  assign ping         = (loop_mode == MODE_PING);
  assign looped       = (loop_mode == MODE_FWD) || ping;
  assign loop_bad     = (loop_end <= loop_start);
  assign len13        = loop_end - loop_start;
  assign len_eff      = ping ? {1'b0, len13, 1'b0} : {2'b00, len13};
  assign vend         = {2'b00, loop_start} + len_eff;
  assign vend32       = POS_W'(vend);
  assign end32        = POS_W'(loop_end);
  assign pos_reserved = (pos == '1);
  assign need_rem     = looped && (pos >= vend32);
  // reflect about the loop end for the backward half of a ping-pong pass
  assign mirror       = {end32[POS_W-2:0], 1'b0} - 32'd1 - pos;
  assign idx          = (ping && (pos >= end32)) ? mirror : pos;
  assign limit        = (POS_W'(sample_length) < DEPTH32) ? POS_W'(sample_length) : DEPTH32;
  assign idx_bad      = (idx >= limit);

  // remainder unit
  rem_status_t       rem_st;
  logic [LEN_W-1:0]  rem;
  logic              rem_start;

  assign rem_start = (state == ST_WRAP) && !pos_reserved && !(looped && loop_bad) && need_rem;

  lsfm_rem_unit u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (pos - vend32),
    .divisor   (len_eff),
    .status    (rem_st),
    .remainder (rem)
  );

  // shared multiplier
  logic signed [WB-1:0]  mul_a;
  logic [15:0]           mul_g;
  logic signed [PW-1:0]  mul_p;
  logic signed [PW-1:0]  prod;
  logic signed [63:0]    prod_ext;
  logic signed [63:0]    scaled;

  assign mul_a    = (state == ST_MUL_L) ? rd_data[2*WB-1:WB] : rd_data[WB-1:0];
  assign mul_g    = (state == ST_MUL_L) ? gain_left : gain_right;
  assign mul_p    = mul_a * $signed({1'b0, mul_g});
  assign prod_ext = {{(64-PW){prod[PW-1]}}, prod};
  assign scaled   = prod_ext >>> gain_shift;

  logic out_load;
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (opcode == OP_MIX)) state_next = ST_WRAP;
      end
      ST_WRAP: begin
        if (pos_reserved || (looped && loop_bad)) state_next = ST_DONE;
        else if (need_rem) state_next = ST_DIV;
        else state_next = ST_INDEX;
      end
      ST_DIV: begin
        if (rem_st.done) state_next = ST_INDEX;
      end
      ST_INDEX: state_next = idx_bad ? ST_DONE : ST_READ;
      ST_READ:  state_next = ST_MUL_L;
      ST_MUL_L: state_next = ST_MUL_R;
      ST_MUL_R: state_next = ST_ADD_R;
      ST_ADD_R: state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          pos   <= play_position;
          acc_l <= accum_left;
          acc_r <= accum_right;
          valid <= 1'b1;
        end
      end
      ST_WRAP: begin
        if (pos_reserved || (looped && loop_bad)) valid <= 1'b0;
      end
      ST_DIV: begin
        if (rem_st.done) pos <= POS_W'(loop_start) + POS_W'(rem);
      end
      ST_INDEX: begin
        if (idx_bad) valid <= 1'b0;
        rd_addr <= AW'(idx);
      end
      ST_MUL_L: prod <= mul_p;
      ST_MUL_R: begin
        mix_l <= acc_l + scaled[31:0];
        prod  <= mul_p;
      end
      ST_ADD_R: mix_r <= acc_r + scaled[31:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mixed_left       <= valid ? mix_l : acc_l;
      mixed_right      <= valid ? mix_r : acc_r;
      wrapped_position <= valid ? pos : '1;
      position_valid   <= valid;
    end
  end

  a_valid_has_position: assert property (@(posedge clk) disable iff (rst)
    (out_valid && position_valid) |-> (wrapped_position != '1))
    else $error("valid result carries the reserved position");

  a_invalid_marks_position: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !position_valid) |-> (wrapped_position == '1))
    else $error("invalid result without reserved position");

  a_div_has_unit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem_st.busy || rem_st.done))
    else $error("waiting on an idle remainder unit");

  a_no_load_when_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && state == ST_DONE) |=> (state == ST_DONE))
    else $error("result left the sequencer while output was full");

endmodule

### rtl/core/lsfm_rem_unit.sv
// lsfm_rem_unit: iterative remainder of a 32-bit position offset by the loop length
// one restoring step per cycle on a shared subtractor; uses lsfm_pkg
module lsfm_rem_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lsfm_pkg::POS_W-1:0]  dividend,
  input  logic [lsfm_pkg::LEN_W-1:0]  divisor,
  output lsfm_pkg::rem_status_t       status,
  output logic [lsfm_pkg::LEN_W-1:0]  remainder
);
  import lsfm_pkg::*;

  logic                busy;
  logic                done;
  logic [4:0]          cnt;
  logic [POS_W-1:0]    dq;
  logic [LEN_W-1:0]    rem;
  logic [LEN_W-1:0]    dvs;
  logic [LEN_W:0]      rem_ext;
  logic [LEN_W+1:0]    trial;
  logic                short_path;

  assign rem_ext    = {rem, dq[POS_W-1]};
  assign trial      = {1'b0, rem_ext} - {2'b00, dvs};
  assign short_path = dividend < {{(POS_W-LEN_W){1'b0}}, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= '0;
        if (short_path) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      dq  <= dividend;
      rem <= short_path ? dividend[LEN_W-1:0] : '0;
    end else if (busy) begin
      dq <= {dq[POS_W-2:0], 1'b0};
      // keep the trial difference unless it went negative
      rem <= trial[LEN_W+1] ? rem_ext[LEN_W-1:0] : trial[LEN_W-1:0];
    end
  end

  assign status    = '{busy: busy, done: done};
  assign remainder = rem;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < dvs))
    else $error("remainder not below loop length");

  a_no_start_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start)
    else $error("remainder unit restarted while busy");

  a_busy_then_done: assert property (@(posedge clk) disable iff (rst)
    (busy && cnt == 5'd31) |=> (done && !busy))
    else $error("remainder unit did not finish after last step");

endmodule

### tb/sv/looped_sample_fetch_mix_checker.sv
`timescale 1ns / 1ps
// looped_sample_fetch_mix_checker: watches the register port and both item channels,
// predicts every mix result from a shadow sample store and register copy, compares in order
// depends on lsfm_pkg
module looped_sample_fetch_mix_checker #(
  parameter int STORE_DEPTH = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [lsfm_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [lsfm_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         opcode,
  input  logic [11:0]                  write_index,
  input  logic signed [15:0]           write_left,
  input  logic signed [15:0]           write_right,
  input  logic [31:0]                  play_position,
  input  logic signed [31:0]           accum_left,
  input  logic signed [31:0]           accum_right,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic signed [31:0]           mixed_left,
  input  logic signed [31:0]           mixed_right,
  input  logic [31:0]                  wrapped_position,
  input  logic                         position_valid,
  input  logic                         drain_check,
  output int                           fail_count
);
  import lsfm_pkg::*;

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
    logic [31:0] pos;
    logic        hit;
  } mix_result_t;

  logic [1:0]  loop_mode;
  logic [12:0] loop_start;
  logic [12:0] loop_end;
  logic [12:0] sample_length;
  logic [15:0] gain_left;
  logic [15:0] gain_right;
  logic [4:0]  gain_shift;

  logic signed [15:0] shadow_left [STORE_DEPTH];
  logic signed [15:0] shadow_right [STORE_DEPTH];
  mix_result_t expected_mixes [$];
  int errors = 0;
  bit drained = 0;

  assign fail_count = errors;

  function automatic logic [31:0] scale_into(logic [31:0] acc, logic signed [15:0] smp,
                                             logic [15:0] gain);
    longint g;
    longint prod;
    g = gain;
    prod = smp * g;
    prod = prod >>> gain_shift;
    return acc + prod[31:0];
  endfunction

  function automatic mix_result_t predict_mix(logic [31:0] position, logic [31:0] acc_l,
                                              logic [31:0] acc_r);
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned span;
    longint unsigned vend;
    longint unsigned limit;
    logic ok;
    mix_result_t r;
    pos = position;
    idx = pos;
    ok = 1'b1;
    if (position == '1) begin
      ok = 1'b0;
    end else if (loop_mode == MODE_FWD || loop_mode == MODE_PING) begin
      if (loop_end <= loop_start) begin
        ok = 1'b0;
      end else begin
        span = loop_end - loop_start;
        vend = loop_end;
        if (loop_mode == MODE_PING) begin
          span = 2 * span;
          vend = loop_start + span;
        end
        if (pos >= vend) pos = loop_start + (pos - vend) % span;
        idx = pos;
        // ping-pong: second half of the doubled loop reads mirrored
        if (loop_mode == MODE_PING && idx >= loop_end) idx = 2 * loop_end - 1 - idx;
      end
    end else if (pos >= sample_length) begin
      ok = 1'b0;
    end
    limit = (sample_length < STORE_DEPTH) ? sample_length : STORE_DEPTH;
    if (ok && idx >= limit) ok = 1'b0;
    if (!ok) begin
      r.left = acc_l;
      r.right = acc_r;
      r.pos = '1;
      r.hit = 1'b0;
    end else begin
      r.left = scale_into(acc_l, shadow_left[idx[11:0]], gain_left);
      r.right = scale_into(acc_r, shadow_right[idx[11:0]], gain_right);
      r.pos = pos[31:0];
      r.hit = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    mix_result_t want;
    int bad;
    if (rst) begin
      loop_mode = MODE_NONE;
      loop_start = '0;
      loop_end = '0;
      sample_length = '0;
      gain_left = '0;
      gain_right = '0;
      gain_shift = '0;
      expected_mixes.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_LOOP_MODE:     loop_mode = cfg_data[1:0];
          CFG_LOOP_START:    loop_start = cfg_data[12:0];
          CFG_LOOP_END:      loop_end = cfg_data[12:0];
          CFG_SAMPLE_LENGTH: sample_length = cfg_data[12:0];
          CFG_GAIN_LEFT:     gain_left = cfg_data[15:0];
          CFG_GAIN_RIGHT:    gain_right = cfg_data[15:0];
          CFG_GAIN_SHIFT:    gain_shift = cfg_data[4:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (expected_mixes.size() == 0) begin
          $display("%0t: mix result with none pending: left=%h right=%h pos=%h valid=%b",
                   $time, mixed_left, mixed_right, wrapped_position, position_valid);
          errors++;
        end else begin
          want = expected_mixes.pop_front();
          bad = int'(want.left !== mixed_left) + int'(want.right !== mixed_right) +
                int'(want.pos !== wrapped_position) + int'(want.hit !== position_valid);
          if (bad != 0) begin
            $display("%0t: mix mismatch: expected left=%h right=%h pos=%h valid=%b, got left=%h right=%h pos=%h valid=%b",
                     $time, want.left, want.right, want.pos, want.hit,
                     mixed_left, mixed_right, wrapped_position, position_valid);
            errors += bad;
          end
        end
      end

      if (in_valid && in_ready) begin
        if (opcode == OP_WRITE) begin
          shadow_left[write_index] = write_left;
          shadow_right[write_index] = write_right;
        end else begin
          expected_mixes.push_back(predict_mix(play_position, accum_left, accum_right));
        end
      end

      if (drain_check && !drained) begin
        drained = 1;
        if (expected_mixes.size() != 0) begin
          $display("%0t: %0d mix results never arrived", $time, expected_mixes.size());
          errors += expected_mixes.size();
        end
      end
    end
  end

endmodule

### tb/sv/looped_sample_fetch_mix_tb.sv
`timescale 1ns / 1ps
// looped_sample_fetch_mix_tb: clock, reset, register setups and item stimulus with random
// idling on both channels; checking lives in looped_sample_fetch_mix_checker
// depends on lsfm_pkg, looped_sample_fetch_mix and looped_sample_fetch_mix_checker
module looped_sample_fetch_mix_tb;
  import lsfm_pkg::*;

  localparam int DRAIN_CYCLES = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REGION_SPAN = 64;
  localparam int RANDOM_PHASES = 15;
  localparam int PHASE_ITEMS = 48;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic        op;
    logic [11:0] widx;
    logic [15:0] wl;
    logic [15:0] wr;
    logic [31:0] pos;
    logic [31:0] al;
    logic [31:0] ar;
  } mix_item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [12:0] lstart;
    logic [12:0] lstop;
    logic [12:0] slen;
  } loop_setup_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                opcode = OP_WRITE;
  logic [11:0]         write_index = '0;
  logic signed [15:0]  write_left = '0;
  logic signed [15:0]  write_right = '0;
  logic [31:0]         play_position = '0;
  logic signed [31:0]  accum_left = '0;
  logic signed [31:0]  accum_right = '0;
  logic                out_valid;
  logic                out_ready = 1'b1;
  logic signed [31:0]  mixed_left;
  logic signed [31:0]  mixed_right;
  logic [31:0]         wrapped_position;
  logic                position_valid;

  int          mixes_sent = 0;
  int          results_seen = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  int          fail_count;
  bit          quiet = 0;
  bit          drain_check = 0;
  bit          written [4096];
  loop_setup_t cur = '0;

  looped_sample_fetch_mix i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .write_index(write_index), .write_left(write_left),
    .write_right(write_right), .play_position(play_position),
    .accum_left(accum_left), .accum_right(accum_right),
    .out_valid(out_valid), .out_ready(out_ready),
    .mixed_left(mixed_left), .mixed_right(mixed_right),
    .wrapped_position(wrapped_position), .position_valid(position_valid)
  );

  looped_sample_fetch_mix_checker i_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .write_index(write_index), .write_left(write_left),
    .write_right(write_right), .play_position(play_position),
    .accum_left(accum_left), .accum_right(accum_right),
    .out_valid(out_valid), .out_ready(out_ready),
    .mixed_left(mixed_left), .mixed_right(mixed_right),
    .wrapped_position(wrapped_position), .position_valid(position_valid),
    .drain_check(drain_check), .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst || quiet || stall_left == 0) begin
      out_ready <= 1'b1;
      if (!rst && !quiet && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) results_seen <= results_seen + 1;
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7fff;
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] pick_accum();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h7fffffff;
    if (r == 1) return 32'h80000000;
    if (r == 2) return '0;
    if (r == 3) return '1;
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_gain();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return 16'hffff;
    return 16'($urandom);
  endfunction

  // an index inside one of the two regions that are always loaded
  function automatic logic [31:0] region_index();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, REGION_SPAN - 1);
    return $urandom_range(4096 - REGION_SPAN, 4095);
  endfunction

  // keeps every store read on an entry that holds data
  function automatic bit read_is_safe(logic [31:0] p);
    if (p >= 4096) return 1;
    if (written[p[11:0]]) return 1;
    return (cur.mode == MODE_FWD || cur.mode == MODE_PING) && cur.lstop > cur.lstart &&
           p >= cur.lstart;
  endfunction

  function automatic mix_item_t noise_item();
    mix_item_t it;
    it.op = 1'($urandom);
    it.widx = 12'($urandom);
    it.wl = 16'($urandom);
    it.wr = 16'($urandom);
    it.pos = $urandom;
    it.al = $urandom;
    it.ar = $urandom;
    return it;
  endfunction

  function automatic mix_item_t random_write();
    mix_item_t it;
    it = noise_item();
    it.op = OP_WRITE;
    it.widx = 12'(($urandom_range(0, 9) < 7) ? region_index() : $urandom_range(0, 4095));
    it.wl = pick_sample();
    it.wr = pick_sample();
    return it;
  endfunction

  function automatic mix_item_t random_mix();
    mix_item_t it;
    int span;
    int r;
    logic [31:0] p;
    it = noise_item();
    it.op = OP_MIX;
    span = (cur.lstop > cur.lstart) ? cur.lstop - cur.lstart : 1;
    r = $urandom_range(0, 15);
    if (r == 0) begin
      p = '1;
    end else if (r == 1) begin
      p = $urandom;
    end else if (r < 4) begin
      p = $urandom_range(0, 1 << 16);
    end else if (r < 8) begin
      p = region_index();
    end else if (r < 14) begin
      if (cur.mode == MODE_FWD || cur.mode == MODE_PING)
        p = cur.lstart + $urandom_range(0, 6 * span);
      else
        p = $urandom_range(0, cur.slen + 2);
    end else begin
      case ($urandom_range(0, 5))
        0: p = cur.lstop - 1;
        1: p = cur.lstop;
        2: p = cur.lstart + 2 * span - 1;
        3: p = cur.lstart + 2 * span;
        4: p = cur.slen - 1;
        default: p = cur.slen;
      endcase
    end
    if (!read_is_safe(p)) p = $urandom_range(0, REGION_SPAN - 1);
    it.pos = p;
    it.al = pick_accum();
    it.ar = pick_accum();
    return it;
  endfunction

  // called at a clock edge; returns at the edge where the item is taken, or after the gap that follows it
  task automatic send_item(input mix_item_t it);
    int gap;
    in_valid <= 1'b1;
    opcode <= it.op;
    write_index <= it.widx;
    write_left <= it.wl;
    write_right <= it.wr;
    play_position <= it.pos;
    accum_left <= it.al;
    accum_right <= it.ar;
    do @(posedge clk); while (!in_ready);
    if (it.op == OP_MIX) mixes_sent++;
    else written[it.widx] = 1;
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic mix(input logic [31:0] pos, input logic [31:0] al, input logic [31:0] ar);
    mix_item_t it;
    it = noise_item();
    it.op = OP_MIX;
    it.pos = pos;
    it.al = al;
    it.ar = ar;
    send_item(it);
  endtask

  task automatic store_write(input logic [11:0] idx, input logic [15:0] l,
                             input logic [15:0] r);
    mix_item_t it;
    it = noise_item();
    it.op = OP_WRITE;
    it.widx = idx;
    it.wl = l;
    it.wr = r;
    send_item(it);
  endtask

  // wait for every pending result, then give a mix without a pending result time to finish
  task automatic settle();
    in_valid <= 1'b0;
    while (results_seen != mixes_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_setup(input logic [1:0] mode, input logic [12:0] lstart,
                             input logic [12:0] lstop, input logic [12:0] slen,
                             input logic [15:0] gl, input logic [15:0] gr,
                             input logic [4:0] shift);
    settle();
    write_reg(CFG_LOOP_MODE, CFG_W'(mode));
    write_reg(CFG_LOOP_START, CFG_W'(lstart));
    write_reg(CFG_LOOP_END, CFG_W'(lstop));
    write_reg(CFG_SAMPLE_LENGTH, CFG_W'(slen));
    write_reg(CFG_GAIN_LEFT, gl);
    write_reg(CFG_GAIN_RIGHT, gr);
    write_reg(CFG_GAIN_SHIFT, CFG_W'(shift));
    cfg_write <= 1'b0;
    cur.mode = mode;
    cur.lstart = lstart;
    cur.lstop = lstop;
    cur.slen = slen;
  endtask

  initial begin
    int ph;
    int n;
    int r;
    int lo;
    logic [1:0] mode;
    logic [12:0] lstart;
    logic [12:0] lstop;
    logic [12:0] slen;
    logic [4:0] shift;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setup: no loop and zero sample length, so every mix is invalid despite the writes
    store_write(12'd0, 16'h7fff, 16'h8000);
    store_write(12'd4095, 16'h8000, 16'h7fff);
    store_write(12'd1, 16'hffff, 16'h0000);
    mix('1, 32'h12345678, 32'h87654321);
    mix(32'd0, 32'h7fffffff, 32'h80000000);
    mix(32'hfffffffe, 32'h0, 32'hffffffff);

    // whole store, full gains, no shift: extreme samples and accumulators
    apply_setup(MODE_NONE, 13'd0, 13'd0, 13'd4096, 16'hffff, 16'hffff, 5'd0);
    mix(32'd4095, 32'h7fffffff, 32'h80000000);
    mix(32'd0, 32'h80000000, 32'h7fffffff);
    mix(32'd1, 32'h0, 32'h0);
    mix(32'd4096, 32'h1, 32'h2);

    // forward loop over two entries, widest shift
    apply_setup(MODE_FWD, 13'd0, 13'd2, 13'd4096, 16'd1, 16'hffff, 5'd31);
    mix(32'd1, 32'h0, 32'h0);
    mix(32'd2, 32'h7fffffff, 32'h80000000);
    mix(32'd7, 32'h0, 32'h0);
    mix(32'hfffffffe, 32'h0, 32'h0);

    // ping-pong over two entries: mirror and double-length wrap
    apply_setup(MODE_PING, 13'd0, 13'd2, 13'd2, 16'h8000, 16'd12345, 5'd15);
    mix(32'd2, 32'h0, 32'h0);
    mix(32'd3, 32'h0, 32'h0);
    mix(32'd4, 32'h0, 32'h0);
    mix(32'd9, 32'h0, 32'h0);

    // spare mode acts as no loop
    apply_setup(MODE_SPARE, 13'd4096, 13'd0, 13'd2, 16'h1234, 16'h4321, 5'd3);
    mix(32'd1, 32'h0, 32'h0);
    mix(32'd4095, 32'h0, 32'h0);

    // inverted loop
    apply_setup(MODE_FWD, 13'd4096, 13'd0, 13'd4096, 16'h1234, 16'h4321, 5'd3);
    mix(32'd0, 32'h0, 32'h0);

    // loop reaches past the sample length
    apply_setup(MODE_FWD, 13'd4095, 13'd4096, 13'd4095, 16'h0100, 16'h0100, 5'd8);
    mix(32'd4095, 32'h0, 32'h0);
    mix(32'd4096, 32'h0, 32'h0);
    mix(32'd1, 32'h0, 32'h0);

    // load the bottom and top regions that the random loops live in
    for (n = 0; n < REGION_SPAN; n++) begin
      store_write(12'(n), pick_sample(), pick_sample());
      store_write(12'(4096 - REGION_SPAN + n), pick_sample(), pick_sample());
    end

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      lo = ($urandom_range(0, 1) == 0) ? 0 : 4096 - REGION_SPAN;
      r = $urandom_range(0, 9);
      mode = (r < 2) ? MODE_NONE : (r < 5) ? MODE_FWD : (r < 9) ? MODE_PING : MODE_SPARE;
      lstart = 13'($urandom_range(lo, lo + REGION_SPAN - 1));
      if ($urandom_range(0, 7) == 0) lstop = 13'($urandom_range(lo, lstart));
      else lstop = 13'($urandom_range(lstart + 1, lo + REGION_SPAN));
      r = $urandom_range(0, 7);
      if (r == 0) slen = 13'd0;
      else if (r == 1) slen = 13'd4096;
      else if (r < 5) slen = 13'($urandom_range(lo, lo + REGION_SPAN));
      else slen = 13'($urandom_range(lstop, lo + REGION_SPAN));
      r = $urandom_range(0, 7);
      shift = (r == 0) ? 5'd0 : (r == 1) ? 5'd31 : 5'($urandom);
      apply_setup(mode, lstart, lstop, slen, pick_gain(), pick_gain(), shift);
      quiet = ($urandom_range(0, 3) == 0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 4) == 0) send_item(random_write());
        else send_item(random_mix());
      end
    end

    settle();
    drain_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/lsfm_pkg.sv
rtl/core/lsfm_rem_unit.sv
rtl/core/looped_sample_fetch_mix.sv
tb/sv/looped_sample_fetch_mix_checker.sv
tb/sv/looped_sample_fetch_mix_tb.sv
